### rtl/pba_pkg.sv
package pba_pkg;

    // default map size in 64-bit words
    localparam int PBA_MAP_WORDS = 256;

    // request codes
    localparam logic [1:0] FUNC_ALLOC_LO = 2'd0;
    localparam logic [1:0] FUNC_ALLOC_HI = 2'd1;
    localparam logic [1:0] FUNC_FREE     = 2'd2;
    localparam logic [1:0] FUNC_RESERVE  = 2'd3;

    typedef struct packed {
        logic [1:0]  func;
        logic [13:0] page_index;
        logic [14:0] count;
    } t_in;

    typedef struct packed {
        logic        ok;
        logic [13:0] first_page;
    } t_out;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_WR_RD,
        ST_WR_WR
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic clr;
        logic load;
        logic scan;
        logic wr_rd;
        logic wr_wr;
        logic fin;
        logic fin_ok;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic bad_n;
        logic found;
        logic scan_end;
        logic w_done;
    } t_sts;

endpackage

### rtl/pba_ctrl.sv
module pba_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [1:0]    i_func,
    input  pba_pkg::t_sts i_sts,
    output pba_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import pba_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = 1'b1;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    if (i_func == FUNC_ALLOC_LO || i_func == FUNC_ALLOC_HI) begin
                        n_state = ST_SCAN;
                    end else begin
                        n_state = ST_WR_RD;
                    end
                end
            end
            ST_SCAN: begin
                if (i_sts.bad_n) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end else if (i_sts.found) begin
                    o_cmd.scan = 1'b1;
                    n_state    = ST_WR_RD;
                end else if (i_sts.scan_end) begin
                    o_cmd.fin = 1'b1;
                    n_state   = ST_IDLE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ST_WR_RD: begin
                if (i_sts.w_done) begin
                    o_cmd.fin    = 1'b1;
                    o_cmd.fin_ok = 1'b1;
                    n_state      = ST_IDLE;
                end else begin
                    o_cmd.wr_rd = 1'b1;
                    n_state     = ST_WR_WR;
                end
            end
            ST_WR_WR: begin
                o_cmd.wr_wr = 1'b1;
                n_state     = ST_WR_RD;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/pba_dp.sv
module pba_dp #(
    parameter int MAP_WORDS = pba_pkg::PBA_MAP_WORDS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pba_pkg::t_in  i_item,
    input  pba_pkg::t_cmd i_cmd,
    output pba_pkg::t_sts o_sts,
    output logic          o_strobe,
    output pba_pkg::t_out o_result
);
    import pba_pkg::*;

    localparam int TOTAL = MAP_WORDS * 64;
    localparam int MIW   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int CW    = $clog2(MAP_WORDS + 1);
    localparam int PGW   = ($clog2(MAP_WORDS) + 8 > 17) ? $clog2(MAP_WORDS) + 8 : 17;
    localparam logic [PGW-1:0] TOT = PGW'(TOTAL);

    logic [63:0] mem [MAP_WORDS];
    logic [63:0] r_rdata;

    logic [1:0]     r_func;
    logic [14:0]    r_n;
    logic [2:0]     r_m;
    logic [5:0]     r_sh;
    logic [CW-1:0]  r_issue;
    logic           r_pvld;
    logic [CW-1:0]  r_pidx;
    logic [PGW-1:0] r_run;
    logic [PGW-1:0] r_wp;
    logic [PGW-1:0] r_wend;
    logic [13:0]    r_first;
    logic [CW-1:0]  r_cnt;
    logic           r_strobe;
    t_out           r_res;

    logic           high;
    logic [63:0]    word;
    logic [63:0]    a [7];
    logic [63:0]    am;
    logic [63:0]    y;
    logic [6:0]     tz;
    logic [6:0]     lead;
    logic [5:0]     j;
    logic           carry_hit;
    logic           int_hit;
    logic           hit;
    logic [PGW-1:0] e_c;
    logic [PGW-1:0] e_i;
    logic [PGW-1:0] spos;
    logic [PGW-1:0] start_pg;
    logic [PGW-1:0] n_run;
    logic [2:0]     ld_m;
    logic [5:0]     ld_sh;
    logic [PGW-1:0] ld_end;
    logic [PGW-1:0] base;
    logic [PGW-1:0] top;
    logic [63:0]    mask;
    logic [63:0]    wdata;
    logic           we;
    logic [MIW-1:0] waddr;
    logic [MIW-1:0] raddr;

    assign high = (r_func == FUNC_ALLOC_HI);

    // scan-order word: bit 0 is the first page met by the search
    always_comb begin
        for (int b = 0; b < 64; b++) begin
            word[b] = high ? r_rdata[63-b] : r_rdata[b];
        end
    end

    // a[k] marks starts of free runs of length 2**k inside the word
    always_comb begin
        a[0] = word;
        for (int k = 1; k < 7; k++) begin
            a[k] = a[k-1] & (a[k-1] >> (1 << (k-1)));
        end
    end

    assign am = a[r_m];
    assign y  = am & (am >> r_sh);

    always_comb begin
        tz   = 7'd64;
        lead = 7'd64;
        j    = 6'd0;
        for (int b = 63; b >= 0; b--) begin
            if (!word[b]) begin
                tz = 7'(b);
            end
            if (y[b]) begin
                j = 6'(b);
            end
        end
        for (int b = 0; b < 64; b++) begin
            if (!word[b]) begin
                lead = 7'(63 - b);
            end
        end
    end

    assign carry_hit = (r_run + PGW'(tz)) >= PGW'(r_n);
    assign int_hit   = (r_n <= 15'd64) && (|y);
    assign hit       = r_pvld && (carry_hit || int_hit);
    assign e_c       = PGW'(r_n) - r_run - PGW'(1);
    assign e_i       = PGW'(j) + PGW'(r_n) - PGW'(1);
    assign spos      = (PGW'(r_pidx) << 6) + PGW'(carry_hit ? e_c[5:0] : e_i[5:0]);
    assign start_pg  = high ? (TOT - PGW'(1) - spos) : (spos + PGW'(1) - PGW'(r_n));
    assign n_run     = (&word) ? (r_run + PGW'(64)) : PGW'(lead);

    // log2 window and residual shift for runs of up to one word
    always_comb begin
        ld_m = 3'd0;
        for (int k = 0; k < 7; k++) begin
            if (i_item.count[k]) begin
                ld_m = 3'(k);
            end
        end
        ld_sh = 6'(i_item.count[6:0] - (7'd1 << ld_m));
    end

    always_comb begin
        ld_end = PGW'(i_item.page_index) + PGW'(i_item.count);
        if (ld_end > TOT) begin
            ld_end = TOT;
        end
    end

    // masked update of one word of a run
    assign base = {r_wp[PGW-1:6], 6'b0};
    assign top  = r_wend - base;

    always_comb begin
        for (int b = 0; b < 64; b++) begin
            mask[b] = (6'(b) >= r_wp[5:0]) && ((top >= PGW'(64)) || (7'(b) < top[6:0]));
        end
    end

    always_comb begin
        if (i_cmd.clr) begin
            wdata = '0;
        end else if (r_func == FUNC_FREE) begin
            wdata = r_rdata | mask;
        end else begin
            wdata = r_rdata & ~mask;
        end
    end

    assign we    = i_cmd.clr || i_cmd.wr_wr;
    assign waddr = i_cmd.clr ? r_cnt[MIW-1:0] : r_wp[6 +: MIW];

    always_comb begin
        if (i_cmd.scan) begin
            raddr = high ? (MIW'(MAP_WORDS - 1) - r_issue[MIW-1:0]) : r_issue[MIW-1:0];
        end else begin
            raddr = r_wp[6 +: MIW];
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        r_rdata <= mem[raddr];
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_issue  <= '0;
            r_pvld   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.fin;
            if (i_cmd.clr) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (i_cmd.load) begin
                r_issue <= '0;
                r_pvld  <= 1'b0;
            end else if (i_cmd.scan) begin
                if (r_issue != CW'(MAP_WORDS)) begin
                    r_issue <= r_issue + CW'(1);
                    r_pvld  <= 1'b1;
                end else begin
                    r_pvld <= 1'b0;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= i_item.func;
            r_n     <= i_item.count;
            r_m     <= ld_m;
            r_sh    <= ld_sh;
            r_run   <= '0;
            r_first <= '0;
            r_wp    <= PGW'(i_item.page_index);
            r_wend  <= ld_end;
        end
        if (i_cmd.scan) begin
            r_pidx <= r_issue;
            if (hit) begin
                r_wp    <= start_pg;
                r_wend  <= start_pg + PGW'(r_n);
                r_first <= start_pg[13:0];
            end else if (r_pvld) begin
                r_run <= n_run;
            end
        end
        if (i_cmd.wr_wr) begin
            r_wp <= base + PGW'(64);
        end
        if (i_cmd.fin) begin
            r_res.ok         <= i_cmd.fin_ok;
            r_res.first_page <= i_cmd.fin_ok ? r_first : 14'd0;
        end
    end

    assign o_sts.clr_last = (r_cnt == CW'(MAP_WORDS - 1));
    assign o_sts.bad_n    = (r_n == 15'd0) || (PGW'(r_n) > TOT);
    assign o_sts.found    = hit;
    assign o_sts.scan_end = (r_issue == CW'(MAP_WORDS)) && !r_pvld;
    assign o_sts.w_done   = (r_wp >= r_wend);

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |=> !r_strobe)
        else $error("result strobe held for two cycles");

    a_rmw_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_wr |-> $past(i_cmd.wr_rd))
        else $error("word written without a read before it");

    a_wr_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_wr |-> (r_wp < r_wend))
        else $error("write past the end of the run");

endmodule

### rtl/page_bitmap_allocator_core.sv
// page bitmap allocator: one bit per page, 1 = free
//
// request channel: present i_item and raise start while busy is low; the beat
// is taken on that clock edge. func selects allocate lowest run, allocate
// highest run, free run or reserve run.
// result channel: exactly one beat per request, o_strobe high for one cycle
// with o_result (ok, first_page). the receiver cannot stall it; busy stays
// high until the strobe cycle, so a new request can be taken in that cycle.
//
// sequence: an allocation scans one map word per cycle through the single
// memory read port, then reads and writes back each map word that the claimed
// run touches; the strobe is registered once the run is written. free and
// reserve read and write back each touched word. an allocation with a zero or
// oversized count fails without a scan.
//
// reset: a clearing pass writes zero to every word, with busy high; afterwards
// all pages read as used.
module page_bitmap_allocator_core #(
    parameter int MAP_WORDS = pba_pkg::PBA_MAP_WORDS
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  pba_pkg::t_in  i_item,
    output logic          o_strobe,
    output pba_pkg::t_out o_result
);
    import pba_pkg::*;

    // command and status between the sequencer and the map datapath
    t_cmd cmd;
    t_sts sts;

    // sequencer: clear pass, scan, read-modify-write loop
    pba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_func  (i_item.func),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // map memory, run search and masked word update
    pba_dp #(
        .MAP_WORDS (MAP_WORDS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_sts    (sts),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
